>>> rtl/core/assert_macros.svh
// Assertion macros for the RTL core files.
// No dependencies; included by modules that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define JSE_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never hold outside reset.
`define JSE_NEVER(lbl, clk, rst_n, cond, msg) \
	`JSE_ASSERT(lbl, clk, rst_n, !(cond), msg)

`endif

>>> rtl/core/jse_pkg.sv
// Types, constants and helper functions for the JSON string escaper.
// No dependencies; used by the stream interfaces and by every core module.
`timescale 1ns / 1ps

package jse_pkg;

	// Field widths
	localparam int ACT_W  = 2;
	localparam int CP_W   = 21;
	localparam int BYTE_W = 8;

	// Longest run of output bytes for one item (surrogate pair escape)
	localparam int MAX_RUN = 12;
	localparam int LEN_W   = $clog2(MAX_RUN + 1);

	// Action codes
	localparam logic [ACT_W-1:0] ACT_OPEN  = 2'd0;
	localparam logic [ACT_W-1:0] ACT_CHAR  = 2'd1;
	localparam logic [ACT_W-1:0] ACT_CLOSE = 2'd2;

	// Configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_SLASH = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ENSURE_ASCII = 1'd1;

	// Codepoint limits and UTF-16 constants
	localparam logic [CP_W-1:0] CP_MAX      = 21'h10FFFF;
	localparam logic [CP_W-1:0] CP_REPL     = 21'h00FFFD;
	localparam logic [CP_W-1:0] CP_BMP_END  = 21'h010000;
	localparam logic [CP_W-1:0] CP_CTRL_END = 21'h000020;
	localparam logic [CP_W-1:0] CP_ASCII    = 21'h00007F;
	localparam logic [15:0]     SURR_HI     = 16'hD800;
	localparam logic [15:0]     SURR_LO     = 16'hDC00;

	// Characters
	localparam logic [BYTE_W-1:0] CH_QUOTE = 8'h22;
	localparam logic [BYTE_W-1:0] CH_BSL   = 8'h5C;
	localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2F;
	localparam logic [BYTE_W-1:0] CH_U     = 8'h75;

	typedef struct packed {
		logic escape_slash;
		logic ensure_ascii;
	} cfg_t;

	// One run of output bytes; bytes[0] goes out first
	typedef struct packed {
		logic [LEN_W-1:0]                len;
		logic [MAX_RUN-1:0][BYTE_W-1:0] bytes;
	} run_t;

	// Lowercase hex digit
	function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] nib);
		logic [BYTE_W-1:0] r;
		if (nib < 4'd10)
			r = 8'h30 + {4'h0, nib};
		else
			r = 8'h57 + {4'h0, nib};
		return r;
	endfunction

	// Second byte of a short escape, zero where there is none
	function automatic logic [BYTE_W-1:0] short_code(input logic [BYTE_W-1:0] c);
		logic [BYTE_W-1:0] r;
		case (c)
			8'h5C:   r = 8'h5C;
			8'h22:   r = 8'h22;
			8'h08:   r = 8'h62;
			8'h0C:   r = 8'h66;
			8'h0A:   r = 8'h6E;
			8'h0D:   r = 8'h72;
			8'h09:   r = 8'h74;
			8'h2F:   r = 8'h2F;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

>>> rtl/core/jse_stream_if.sv
// Valid/ready stream interfaces for the escaper's input and output items.
// Depends on jse_pkg for field widths.
`timescale 1ns / 1ps

interface jse_in_if;
	logic                        valid;
	logic                        ready;
	logic [jse_pkg::ACT_W-1:0]   action;
	logic [jse_pkg::CP_W-1:0]    codepoint;

	modport source (output valid, action, codepoint, input ready);
	modport sink   (input valid, action, codepoint, output ready);
endinterface

interface jse_out_if;
	logic                        valid;
	logic                        ready;
	logic [jse_pkg::BYTE_W-1:0]  out_byte;
	logic                        end_of_run;

	modport source (output valid, out_byte, end_of_run, input ready);
	modport sink   (input valid, out_byte, end_of_run, output ready);
endinterface

>>> rtl/core/json_string_escaper_unit.sv
// JSON string escaper top level: input register, encoder, output serializer.
// in_ch items: action (0 open quote, 1 codepoint, 2 close quote) and codepoint.
// out_ch items: one escaped byte each, end_of_run set on the last byte of a run.
// Configuration: cfg_we writes cfg_data into register cfg_index
// (0 escape_slash, 1 ensure_ascii); write only while no item is in flight.
// An item passes the input register and then the result register; the first
// byte of an item is presented once the result register has loaded it.
// Throughput: an item producing n bytes holds the single byte-wide output port
// until its n bytes are taken; items that escape to one byte flow at one per
// cycle while out_ch is ready. Action code 3 produces nothing and is never loaded.
// When out_ch stalls the result register holds its byte, the input register
// fills, and in_ch.ready drops until the run drains.
// Reset (arst_n low) empties both registers and clears both config bits.
// Depends on jse_pkg, jse_stream_if, jse_encoder, jse_serializer, assert_macros.svh.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module json_string_escaper_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	jse_in_if.sink                        in_ch,
	jse_out_if.source                     out_ch,
	input  logic                          cfg_we,
	input  logic [jse_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic                          cfg_data
);
	import jse_pkg::*;

	cfg_t            cfg_q;
	logic            valid_s1;
	logic [ACT_W-1:0] action_s1;
	logic [CP_W-1:0] cp_s1;
	run_t            run;
	logic            load_ready;
	logic            load;
	logic            adv_s1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ESCAPE_SLASH: cfg_q.escape_slash <= cfg_data;
				REG_ENSURE_ASCII: cfg_q.ensure_ascii <= cfg_data;
				default:          cfg_q <= cfg_q;
			endcase
		end
	end

	// Input register handshake: empty runs retire without a load
	assign adv_s1      = valid_s1 && ((run.len == '0) || load_ready);
	assign load        = valid_s1 && (run.len != '0) && load_ready;
	assign in_ch.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			action_s1 <= in_ch.action;
			cp_s1     <= in_ch.codepoint;
		end
	end

	jse_encoder u_enc (
		.action    (action_s1),
		.codepoint (cp_s1),
		.cfg       (cfg_q),
		.run       (run)
	);

	jse_serializer u_ser (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (load),
		.run        (run),
		.load_ready (load_ready),
		.out_ch     (out_ch)
	);

	// Checks
	`JSE_ASSERT(a_s1_hold, clk, arst_n, valid_s1 && !adv_s1 |=> valid_s1 && $stable(cp_s1) && $stable(action_s1), "input register lost a stalled item")
	`JSE_ASSERT(a_load_free, clk, arst_n, load |-> !out_ch.valid || (out_ch.ready && out_ch.end_of_run), "run loaded over undelivered bytes")
	`JSE_NEVER(a_empty_ready, clk, arst_n, !valid_s1 && !in_ch.ready, "input blocked while input register empty")

endmodule

>>> rtl/core/jse_encoder.sv
// Combinational escaper: one registered item in, one run of output bytes out.
// Depends on jse_pkg.
`timescale 1ns / 1ps

module jse_encoder (
	input  logic [jse_pkg::ACT_W-1:0] action,
	input  logic [jse_pkg::CP_W-1:0]  codepoint,
	input  jse_pkg::cfg_t             cfg,
	output jse_pkg::run_t             run
);
	import jse_pkg::*;

	logic [CP_W-1:0]   cp;
	logic [CP_W-1:0]   off;
	logic [15:0]       hi;
	logic [15:0]       lo;
	logic [15:0]       bmp;
	logic [BYTE_W-1:0] sc;
	logic              esc;

	// Clamp out-of-range values and decide whether to escape
	always_comb begin
		cp  = (codepoint > CP_MAX) ? CP_REPL : codepoint;
		esc = (cp == {13'd0, CH_BSL}) || (cp == {13'd0, CH_QUOTE}) || (cp < CP_CTRL_END);
		if (cfg.escape_slash && cp == {13'd0, CH_SLASH})
			esc = 1'b1;
		if (cfg.ensure_ascii && cp > CP_ASCII)
			esc = 1'b1;
		sc  = (cp[CP_W-1:BYTE_W] == '0) ? short_code(cp[BYTE_W-1:0]) : '0;
		off = cp - CP_BMP_END;
		hi  = SURR_HI | {6'd0, off[19:10]};
		lo  = SURR_LO | {6'd0, off[9:0]};
		bmp = cp[15:0];
	end

	// Build the byte run
	always_comb begin
		run = '0;
		case (action) inside
			ACT_OPEN, ACT_CLOSE: begin
				run.len      = LEN_W'(1);
				run.bytes[0] = CH_QUOTE;
			end
			ACT_CHAR: begin
				if (!esc) begin
					// plain UTF-8
					if (cp < 21'h80) begin
						run.len      = LEN_W'(1);
						run.bytes[0] = cp[7:0];
					end else if (cp < 21'h800) begin
						run.len      = LEN_W'(2);
						run.bytes[0] = {3'b110, cp[10:6]};
						run.bytes[1] = {2'b10, cp[5:0]};
					end else if (cp < CP_BMP_END) begin
						run.len      = LEN_W'(3);
						run.bytes[0] = {4'b1110, cp[15:12]};
						run.bytes[1] = {2'b10, cp[11:6]};
						run.bytes[2] = {2'b10, cp[5:0]};
					end else begin
						run.len      = LEN_W'(4);
						run.bytes[0] = {5'b11110, cp[20:18]};
						run.bytes[1] = {2'b10, cp[17:12]};
						run.bytes[2] = {2'b10, cp[11:6]};
						run.bytes[3] = {2'b10, cp[5:0]};
					end
				end else if (sc != '0) begin
					// two-byte short escape
					run.len      = LEN_W'(2);
					run.bytes[0] = CH_BSL;
					run.bytes[1] = sc;
				end else if (cp < CP_BMP_END) begin
					run.len      = LEN_W'(6);
					run.bytes[0] = CH_BSL;
					run.bytes[1] = CH_U;
					run.bytes[2] = hex_char(bmp[15:12]);
					run.bytes[3] = hex_char(bmp[11:8]);
					run.bytes[4] = hex_char(bmp[7:4]);
					run.bytes[5] = hex_char(bmp[3:0]);
				end else begin
					// surrogate pair
					run.len       = LEN_W'(12);
					run.bytes[0]  = CH_BSL;
					run.bytes[1]  = CH_U;
					run.bytes[2]  = hex_char(hi[15:12]);
					run.bytes[3]  = hex_char(hi[11:8]);
					run.bytes[4]  = hex_char(hi[7:4]);
					run.bytes[5]  = hex_char(hi[3:0]);
					run.bytes[6]  = CH_BSL;
					run.bytes[7]  = CH_U;
					run.bytes[8]  = hex_char(lo[15:12]);
					run.bytes[9]  = hex_char(lo[11:8]);
					run.bytes[10] = hex_char(lo[7:4]);
					run.bytes[11] = hex_char(lo[3:0]);
				end
			end
			default: run = '0;
		endcase
	end

endmodule

>>> rtl/core/jse_serializer.sv
// Result register: holds one byte run and shifts it out one byte per item.
// Depends on jse_pkg and jse_stream_if.
`timescale 1ns / 1ps

module jse_serializer (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  jse_pkg::run_t run,
	output logic          load_ready,
	jse_out_if.source     out_ch
);
	import jse_pkg::*;

	logic [MAX_RUN-1:0][BYTE_W-1:0] bytes_s2;
	logic [LEN_W-1:0]               cnt_s2;
	logic                           take;

	assign take       = out_ch.valid && out_ch.ready;
	assign load_ready = (cnt_s2 == '0) || (take && cnt_s2 == LEN_W'(1));

	// Remaining byte count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_s2 <= '0;
		end else if (load) begin
			cnt_s2 <= run.len;
		end else if (take) begin
			cnt_s2 <= cnt_s2 - LEN_W'(1);
		end
	end

	// Byte shift register, head at index 0
	always_ff @(posedge clk) begin
		if (load) begin
			bytes_s2 <= run.bytes;
		end else if (take) begin
			bytes_s2 <= {{BYTE_W{1'b0}}, bytes_s2[MAX_RUN-1:1]};
		end
	end

	assign out_ch.valid      = (cnt_s2 != '0);
	assign out_ch.out_byte   = bytes_s2[0];
	assign out_ch.end_of_run = (cnt_s2 == LEN_W'(1));

endmodule

>>> verif/tb_json_string_escaper_unit.sv
// Self-checking bench for json_string_escaper_unit: directed and random strings,
// predicted escaped bytes compared per output item. Depends on jse_pkg and jse_stream_if.
`timescale 1ns / 1ps

module tb_json_string_escaper_unit;
	import jse_pkg::*;

	localparam int LIMIT_CYCLES   = 200000;
	localparam int DRAIN_CYCLES   = 8;
	localparam int HOLDOFF_CYCLES = 400;

	// Action code that the block drops without output
	localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

	// Receiver stall patterns
	typedef enum int {RX_STREAM, RX_MOSTLY, RX_SPARSE, RX_PERIODIC} rx_mode_t;

	// Escaped bytes for one input item; b[0] goes out first
	typedef struct packed {
		logic [3:0]       count;
		logic [11:0][7:0] b;
	} esc_run_t;

	// One expected output item
	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} out_item_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic cfg_data;

	jse_in_if  in_ch ();
	jse_out_if out_ch ();

	json_string_escaper_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Bench copy of the configuration registers
	logic model_escape_slash;
	logic model_ensure_ascii;

	out_item_t expected_bytes[$];
	esc_run_t  accepted_run;
	out_item_t oldest_byte;

	int cycle_count;
	int error_count;
	int items_accepted;
	int bytes_checked;
	int config_writes;
	int burst_left;
	bit no_gaps;
	int holdoff_req;
	int holdoff_ack;
	int holdoff_done;
	rx_mode_t rx_mode;
	int rx_left;
	int rx_phase;
	int k;

	always #1 clk = ~clk;

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d bytes still due", cycle_count,
				expected_bytes.size());
			$display("json_string_escaper_unit: mismatch");
			$finish;
		end
	end

	task automatic report_error(input string msg);
		error_count++;
		$display("ERROR cycle %0d: %s", cycle_count, msg);
	endtask

	function automatic void push_byte(inout esc_run_t r, input logic [7:0] x);
		r.b[r.count] = x;
		r.count = r.count + 4'd1;
	endfunction

	function automatic logic [7:0] hex_digit(input logic [3:0] nib);
		if (nib < 4'd10)
			return "0" + {4'h0, nib};
		return "a" + {4'h0, nib} - 8'd10;
	endfunction

	// Backslash, u and four lowercase hex digits
	function automatic void push_u_escape(inout esc_run_t r, input logic [15:0] v);
		push_byte(r, CH_BSL);
		push_byte(r, CH_U);
		push_byte(r, hex_digit(v[15:12]));
		push_byte(r, hex_digit(v[11:8]));
		push_byte(r, hex_digit(v[7:4]));
		push_byte(r, hex_digit(v[3:0]));
	endfunction

	// Letter of a two-byte escape, zero where the codepoint has none
	function automatic logic [7:0] short_letter(input logic [CP_W-1:0] c);
		case (c)
			21'h5C:  return CH_BSL;
			21'h22:  return CH_QUOTE;
			21'h2F:  return CH_SLASH;
			21'h08:  return "b";
			21'h0C:  return "f";
			21'h0A:  return "n";
			21'h0D:  return "r";
			21'h09:  return "t";
			default: return 8'h00;
		endcase
	endfunction

	// Escaped output bytes for one input item under the given settings
	function automatic esc_run_t escape_item(input logic [ACT_W-1:0] act,
			input logic [CP_W-1:0] code, input logic esc_slash, input logic ascii_only);
		esc_run_t r;
		logic [CP_W-1:0] c;
		logic need_esc;
		logic [7:0] letter;
		logic [19:0] off;
		r = '0;
		if (act == ACT_OPEN || act == ACT_CLOSE) begin
			push_byte(r, CH_QUOTE);
		end else if (act == ACT_CHAR) begin
			// out-of-range values become the replacement character
			c = (code > CP_MAX) ? CP_REPL : code;
			need_esc = (c == 21'h5C) || (c == 21'h22) || (c < 21'h20) ||
				(esc_slash && c == 21'h2F) || (ascii_only && c > 21'h7F);
			if (!need_esc) begin
				if (c < 21'h80) begin
					push_byte(r, c[7:0]);
				end else if (c < 21'h800) begin
					push_byte(r, {3'b110, c[10:6]});
					push_byte(r, {2'b10, c[5:0]});
				end else if (c < 21'h10000) begin
					push_byte(r, {4'b1110, c[15:12]});
					push_byte(r, {2'b10, c[11:6]});
					push_byte(r, {2'b10, c[5:0]});
				end else begin
					push_byte(r, {5'b11110, c[20:18]});
					push_byte(r, {2'b10, c[17:12]});
					push_byte(r, {2'b10, c[11:6]});
					push_byte(r, {2'b10, c[5:0]});
				end
			end else begin
				letter = short_letter(c);
				if (letter != 8'h00) begin
					push_byte(r, CH_BSL);
					push_byte(r, letter);
				end else if (c < 21'h10000) begin
					push_u_escape(r, c[15:0]);
				end else begin
					// surrogate pair above the BMP
					off = 20'(c - 21'h10000);
					push_u_escape(r, SURR_HI | {6'b0, off[19:10]});
					push_u_escape(r, SURR_LO | {6'b0, off[9:0]});
				end
			end
		end
		return r;
	endfunction

	// Predict on input acceptance, check on output acceptance
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready) begin
				accepted_run = escape_item(in_ch.action, in_ch.codepoint,
					model_escape_slash, model_ensure_ascii);
				for (k = 0; k < int'(accepted_run.count); k++)
					expected_bytes.push_back({accepted_run.b[k],
						k == int'(accepted_run.count) - 1});
				items_accepted++;
			end
			if (out_ch.valid && out_ch.ready) begin
				if (expected_bytes.size() == 0) begin
					report_error($sformatf("byte 0x%02h with none expected", out_ch.out_byte));
				end else begin
					oldest_byte = expected_bytes.pop_front();
					if (out_ch.out_byte !== oldest_byte.ch)
						report_error($sformatf("out_byte 0x%02h, expected 0x%02h",
							out_ch.out_byte, oldest_byte.ch));
					if (out_ch.end_of_run !== oldest_byte.last)
						report_error($sformatf("end_of_run %0b, expected %0b on byte 0x%02h",
							out_ch.end_of_run, oldest_byte.last, oldest_byte.ch));
					bytes_checked++;
				end
			end
		end
	end

	// Receiver: changing stall patterns, plus a long hold-off on request
	initial begin
		out_ch.ready <= 1'b0;
		rx_left = 0;
		rx_phase = 0;
		forever begin
			@(posedge clk);
			if (holdoff_req != holdoff_ack) begin
				holdoff_ack = holdoff_req;
				out_ch.ready <= 1'b0;
				repeat (HOLDOFF_CYCLES) @(posedge clk);
				holdoff_done++;
			end else begin
				if (rx_left == 0) begin
					rx_mode = rx_mode_t'($urandom_range(0, 3));
					rx_left = $urandom_range(16, 80);
				end
				rx_left--;
				rx_phase++;
				case (rx_mode)
					RX_STREAM: begin
						out_ch.ready <= 1'b1;
					end
					RX_MOSTLY: begin
						out_ch.ready <= ($urandom_range(0, 3) != 0);
					end
					RX_SPARSE: begin
						out_ch.ready <= ($urandom_range(0, 3) == 0);
					end
					default: begin
						out_ch.ready <= (rx_phase % 4 != 0);
					end
				endcase
			end
		end
	end

	// Sender pacing: random bursts separated by random gaps
	task automatic pace();
		int gap;
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = (no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Offer one item and wait for the handshake; called at a rising edge
	task automatic send_item(input logic [ACT_W-1:0] act, input logic [CP_W-1:0] code);
		in_ch.valid     <= 1'b1;
		in_ch.action    <= act;
		in_ch.codepoint <= code;
		do @(posedge clk); while (!in_ch.ready);
		pace();
	endtask

	task automatic send_char(input logic [CP_W-1:0] code);
		send_item(ACT_CHAR, code);
	endtask

	// Stop offering and wait until all output has come, plus a margin of DRAIN_CYCLES
	task automatic drain();
		in_ch.valid <= 1'b0;
		while (expected_bytes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write both registers; only while the block is idle
	task automatic set_config(input logic esc_slash, input logic ascii_only);
		cfg_we    <= 1'b1;
		cfg_index <= REG_ESCAPE_SLASH;
		cfg_data  <= esc_slash;
		@(posedge clk);
		model_escape_slash = esc_slash;
		cfg_index <= REG_ENSURE_ASCII;
		cfg_data  <= ascii_only;
		@(posedge clk);
		model_ensure_ascii = ascii_only;
		cfg_we <= 1'b0;
		config_writes++;
	endtask

	function automatic logic [CP_W-1:0] pick_codepoint();
		case ($urandom_range(0, 11))
			0:       return 21'($urandom_range(0, 21'h1F));
			1: begin
				case ($urandom_range(0, 2))
					0:       return 21'h22;
					1:       return 21'h5C;
					default: return 21'h2F;
				endcase
			end
			2, 3:    return 21'($urandom_range(21'h20, 21'h7F));
			4:       return 21'($urandom_range(21'h80, 21'h7FF));
			5:       return 21'($urandom_range(21'h800, 21'hFFFF));
			6:       return 21'($urandom_range(21'hD800, 21'hDFFF));
			7, 8:    return 21'($urandom_range(21'h10000, 21'h10FFFF));
			9:       return 21'($urandom_range(21'h110000, 21'h1FFFFF));
			default: return 21'($urandom());
		endcase
	endfunction

	// One quoted string of random characters; sometimes broken or with noise
	task automatic send_random_string(input int nchars);
		int i;
		if ($urandom_range(0, 7) != 0)
			send_item(ACT_OPEN, 21'($urandom()));
		for (i = 0; i < nchars; i++) begin
			if ($urandom_range(0, 9) == 0)
				send_item(ACT_UNUSED, 21'($urandom()));
			send_char(pick_codepoint());
		end
		if ($urandom_range(0, 7) != 0)
			send_item(ACT_CLOSE, 21'($urandom()));
	endtask

	// Quote markers ignore the codepoint; the unused action gives nothing
	task automatic test_markers();
		send_item(ACT_OPEN, 21'h1FFFFF);
		send_item(ACT_UNUSED, 21'h000041);
		send_item(ACT_CLOSE, 21'h000000);
		drain();
	endtask

	// Always-escaped codes at reset settings: short forms and \u00XX
	task automatic test_short_escapes();
		send_item(ACT_OPEN, 21'h0);
		send_char(21'h22);
		send_char(21'h5C);
		send_char(21'h08);
		send_char(21'h0C);
		send_char(21'h0A);
		send_char(21'h0D);
		send_char(21'h09);
		send_char(21'h00);
		send_char(21'h1F);
		send_item(ACT_CLOSE, 21'h0);
		drain();
	endtask

	// Plain UTF-8 at reset settings, each encoded length and the clamp
	task automatic test_utf8_passthrough();
		send_char(21'h20);
		send_char(21'h2F);
		send_char(21'h7F);
		send_char(21'h80);
		send_char(21'hD800);
		send_char(21'hFFFF);
		send_char(21'h10FFFF);
		send_char(21'h110000);
		drain();
	endtask

	// Slash and non-ASCII escaping, surrogate pairs, replacement above the range
	task automatic test_forced_escapes();
		set_config(1'b1, 1'b1);
		send_char(21'h2F);
		send_char(21'h7F);
		send_char(21'h80);
		send_char(21'hDFFF);
		send_char(21'h10000);
		send_char(21'h10FFFF);
		send_char(21'h1FFFFF);
		drain();
	endtask

	// Random strings under every setting
	task automatic test_random_strings();
		int phase;
		int sent;
		int n;
		for (phase = 0; phase < 4; phase++) begin
			set_config(phase[0] ^ phase[1], phase[1]);
			no_gaps = (phase == 2);
			sent = 0;
			while (sent < 22) begin
				n = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
				send_random_string(n);
				sent += n + 2;
			end
			drain();
		end
		no_gaps = 1'b0;
	endtask

	// Receiver holds off long while the sender keeps offering long escapes
	task automatic test_output_holdoff();
		int i;
		set_config(1'b0, 1'b1);
		no_gaps = 1'b1;
		holdoff_req++;
		for (i = 0; i < 24; i++)
			send_char(21'($urandom_range(21'h80, 21'h10FFFF)));
		drain();
		no_gaps = 1'b0;
	endtask

	initial begin
		cycle_count = 0;
		error_count = 0;
		items_accepted = 0;
		bytes_checked = 0;
		config_writes = 0;
		burst_left = 0;
		no_gaps = 1'b0;
		holdoff_req = 0;
		holdoff_ack = 0;
		holdoff_done = 0;
		model_escape_slash = 1'b0;
		model_ensure_ascii = 1'b0;
		arst_n          <= 1'b0;
		cfg_we          <= 1'b0;
		cfg_index       <= REG_ESCAPE_SLASH;
		cfg_data        <= 1'b0;
		in_ch.valid     <= 1'b0;
		in_ch.action    <= ACT_OPEN;
		in_ch.codepoint <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_markers();
		test_short_escapes();
		test_utf8_passthrough();
		test_forced_escapes();
		test_random_strings();
		test_output_holdoff();

		$display("run covered %0d input items and %0d output bytes over %0d register settings,",
			items_accepted, bytes_checked, config_writes);
		$display("with %0d long output hold-off(s) and %0d errors", holdoff_done, error_count);
		if (error_count == 0)
			$display("json_string_escaper_unit: match");
		else
			$display("json_string_escaper_unit: mismatch");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/jse_pkg.sv
rtl/core/jse_stream_if.sv
rtl/core/jse_encoder.sv
rtl/core/jse_serializer.sv
rtl/core/json_string_escaper_unit.sv
verif/tb_json_string_escaper_unit.sv
